// File: rtl/core/caq_pkg.sv
package caq_pkg;

    localparam int WORD_W = 32;
    localparam int KIND_W = 2;
    localparam int POS_W = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 4;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_ENQ = 2'd0;
    localparam kind_t KIND_DEQ = 2'd1;
    localparam kind_t KIND_READ = 2'd2;
    localparam kind_t KIND_WRITE = 2'd3;

    localparam status_t STATUS_OK = 2'd0;
    localparam status_t STATUS_FULL = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;
    localparam status_t STATUS_RANGE = 2'd3;

    // per-slot control from the queue controller
    typedef struct packed {
        logic shift;
        logic wr;
    } slot_ctrl_t;

endpackage

// File: rtl/core/caq_cell.sv
module caq_cell (
    input  logic                aclk,
    input  caq_pkg::slot_ctrl_t ctrl,
    input  caq_pkg::word_t      upper_word,
    input  caq_pkg::word_t      wr_word,
    output caq_pkg::word_t      word
);

    caq_pkg::word_t word_reg;
    caq_pkg::word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.wr) begin
            word_next = wr_word;
        end else if (ctrl.shift) begin
            word_next = upper_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: rtl/core/compacting_array_queue_core.sv
// Linear array queue of DEPTH signed 32-bit words with compaction.
// Input channel s_*: tuser carries the operation kind (enqueue, dequeue,
// read at position, write at position), tdata the value and position.
// Result channel m_*: one item per input item, tuser carries the status,
// tdata the dequeued or read word, occupancy and the empty and full flags.
// A result other than a compacting enqueue's is presented the cycle after its input item is taken.
// An enqueue that finds the tail at the last slot while the head is not at
// slot 0 first compacts: the row of slots shifts down by one slot per cycle
// until the head reaches slot 0.
// A new item is taken in the cycle its predecessor's result leaves the output
// register, so the rate is one item per cycle on plain operations while the
// receiver takes each result, lower when compaction runs.
// Reset empties the queue (head and tail at 0); slot contents are kept.
// When the receiver stalls, the result holds in the output register and
// s_tready stays low until it is taken.
module compacting_array_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[34:32], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], occupancy[35:32], is_empty[36],
                                   // is_full[37], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WCNT_W = (CNT_W > caq_pkg::OCC_W) ? CNT_W : caq_pkg::OCC_W;
    localparam int CMP_W = (IDX_W > caq_pkg::POS_W) ? IDX_W : caq_pkg::POS_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COMPACT = 1'b1;

    logic state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic empty_reg, empty_next;
    caq_pkg::word_t pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    caq_pkg::status_t status_reg, status_next;
    caq_pkg::word_t data_reg, data_next;
    logic [caq_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic is_empty_reg, is_empty_next;
    logic is_full_reg, is_full_next;

    caq_pkg::kind_t in_kind;
    caq_pkg::word_t in_value;
    logic [caq_pkg::POS_W-1:0] in_pos;
    logic fire;
    logic load;
    logic do_shift;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    caq_pkg::word_t wr_word;
    logic [IDX_W-1:0] rd_idx;
    logic full_now;
    logic in_range;
    logic [WCNT_W-1:0] count;

    caq_pkg::word_t slot_q [DEPTH];

    assign in_kind = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_pos = s_tdata[34:32];

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign fire = s_tvalid && s_tready;

    assign full_now = !empty_reg && (head_reg == '0) && (tail_reg == LAST);
    assign in_range = (CMP_W'(in_pos) >= CMP_W'(head_reg))
                   && (CMP_W'(in_pos) <= CMP_W'(tail_reg));
    assign rd_idx = (in_kind == caq_pkg::KIND_DEQ) ? head_reg : IDX_W'(in_pos);

    always_comb begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        empty_next = empty_reg;
        pend_next = pend_reg;
        load = 1'b0;
        do_shift = 1'b0;
        wr_en = 1'b0;
        wr_idx = '0;
        wr_word = in_value;
        status_next = caq_pkg::STATUS_OK;
        data_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    load = 1'b1;
                    case (in_kind)
                        caq_pkg::KIND_ENQ: begin
                            if (full_now) begin
                                status_next = caq_pkg::STATUS_FULL;
                            end else if (empty_reg) begin
                                head_next = '0;
                                tail_next = '0;
                                empty_next = 1'b0;
                                wr_en = 1'b1;
                                wr_idx = '0;
                            end else if (tail_reg == LAST) begin
                                load = 1'b0;
                                pend_next = in_value;
                                state_next = ST_COMPACT;
                            end else begin
                                tail_next = tail_reg + 1'b1;
                                wr_en = 1'b1;
                                wr_idx = tail_reg + 1'b1;
                            end
                        end
                        caq_pkg::KIND_DEQ: begin
                            if (empty_reg) begin
                                status_next = caq_pkg::STATUS_EMPTY;
                            end else begin
                                data_next = slot_q[rd_idx];
                                if (head_reg == tail_reg) begin
                                    head_next = '0;
                                    tail_next = '0;
                                    empty_next = 1'b1;
                                end else begin
                                    head_next = head_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (empty_reg) begin
                                status_next = caq_pkg::STATUS_EMPTY;
                            end else if (!in_range) begin
                                status_next = caq_pkg::STATUS_RANGE;
                            end else if (in_kind == caq_pkg::KIND_READ) begin
                                data_next = slot_q[rd_idx];
                            end else begin
                                wr_en = 1'b1;
                                wr_idx = IDX_W'(in_pos);
                            end
                        end
                    endcase
                end
            end
            ST_COMPACT: begin
                if (head_reg != '0) begin
                    do_shift = 1'b1;
                    head_next = head_reg - 1'b1;
                    tail_next = tail_reg - 1'b1;
                end else begin
                    tail_next = tail_reg + 1'b1;
                    wr_en = 1'b1;
                    wr_idx = tail_reg + 1'b1;
                    wr_word = pend_reg;
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result flags follow the queue state after the operation
    assign count = empty_next ? '0
                 : WCNT_W'(WCNT_W'(tail_next) - WCNT_W'(head_next) + WCNT_W'(1));
    assign occ_next = count[caq_pkg::OCC_W-1:0];
    assign is_empty_next = empty_next;
    assign is_full_next = !empty_next && (head_next == '0) && (tail_next == LAST);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_slot
            caq_pkg::slot_ctrl_t ctrl;
            caq_pkg::word_t upper;
            assign ctrl.shift = do_shift;
            assign ctrl.wr = wr_en && (wr_idx == IDX_W'(gi));
            if (gi == DEPTH - 1) begin : g_top
                assign upper = slot_q[gi];
            end else begin : g_mid
                assign upper = slot_q[gi+1];
            end
            caq_cell u_slot (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .upper_word (upper),
                .wr_word    (wr_word),
                .word       (slot_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            empty_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            empty_reg <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (load) begin
            status_reg <= status_next;
            data_reg <= data_next;
            occ_reg <= occ_next;
            is_empty_reg <= is_empty_next;
            is_full_reg <= is_full_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = status_reg;
    assign m_tdata = {2'b00, is_full_reg, is_empty_reg, occ_reg, data_reg};

endmodule

// File: test/compacting_array_queue_checker.sv
`timescale 1ns / 1ps

module compacting_array_queue_checker #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        caq_pkg::status_t status;
        caq_pkg::word_t   data;
        logic [3:0]       occupancy;
        logic             is_empty;
        logic             is_full;
    } queue_result_t;

    caq_pkg::word_t slots [DEPTH];
    int             head_idx;
    int             tail_idx;
    logic           no_entries;
    queue_result_t  awaited_q [$];

    initial mismatches = 0;
    initial pending = 0;

    function automatic logic queue_is_full();
        return !no_entries && head_idx == 0 && tail_idx == DEPTH - 1;
    endfunction

    function automatic queue_result_t apply_queue_op(caq_pkg::kind_t kind,
                                                     caq_pkg::word_t value, int pos);
        queue_result_t r;
        r.status = caq_pkg::STATUS_OK;
        r.data = '0;
        case (kind)
            caq_pkg::KIND_ENQ: begin
                if (queue_is_full()) begin
                    r.status = caq_pkg::STATUS_FULL;
                end else if (no_entries) begin
                    head_idx = 0;
                    tail_idx = 0;
                    no_entries = 1'b0;
                    slots[0] = value;
                end else begin
                    if (tail_idx == DEPTH - 1) begin
                        // compaction: live entries move down to slot 0
                        for (int i = head_idx; i <= tail_idx; i++)
                            slots[i - head_idx] = slots[i];
                        tail_idx = tail_idx - head_idx;
                        head_idx = 0;
                    end
                    tail_idx = tail_idx + 1;
                    slots[tail_idx] = value;
                end
            end
            caq_pkg::KIND_DEQ: begin
                if (no_entries) begin
                    r.status = caq_pkg::STATUS_EMPTY;
                end else begin
                    r.data = slots[head_idx];
                    if (head_idx == tail_idx) begin
                        head_idx = 0;
                        tail_idx = 0;
                        no_entries = 1'b1;
                    end else begin
                        head_idx = head_idx + 1;
                    end
                end
            end
            default: begin
                if (no_entries) begin
                    r.status = caq_pkg::STATUS_EMPTY;
                end else if (pos < head_idx || pos > tail_idx) begin
                    r.status = caq_pkg::STATUS_RANGE;
                end else if (kind == caq_pkg::KIND_READ) begin
                    r.data = slots[pos];
                end else begin
                    slots[pos] = value;
                end
            end
        endcase
        r.occupancy = no_entries ? 4'd0 : 4'(tail_idx - head_idx + 1);
        r.is_empty = no_entries;
        r.is_full = queue_is_full();
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            head_idx = 0;
            tail_idx = 0;
            no_entries = 1'b1;
            foreach (slots[i]) slots[i] = '0;
            awaited_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited_q.push_back(apply_queue_op(caq_pkg::kind_t'(s_tuser),
                                                   caq_pkg::word_t'(s_tdata[31:0]),
                                                   int'(s_tdata[34:32])));
            if (m_tvalid && m_tready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[31:0], '0);
                end else begin
                    want = awaited_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.data)
                        report_mismatch("data", m_tdata[31:0], want.data);
                    if (m_tdata[35:32] !== want.occupancy)
                        report_mismatch("occupancy", 32'(m_tdata[35:32]), 32'(want.occupancy));
                    if (m_tdata[36] !== want.is_empty)
                        report_mismatch("is_empty", 32'(m_tdata[36]), 32'(want.is_empty));
                    if (m_tdata[37] !== want.is_full)
                        report_mismatch("is_full", 32'(m_tdata[37]), 32'(want.is_full));
                end
            end
        end
        pending <= awaited_q.size();
    end

endmodule

// File: test/compacting_array_queue_core_test.sv
`timescale 1ns / 1ps

module compacting_array_queue_core_test;

    localparam int DEPTH = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = caq_pkg::KIND_ENQ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    int          mismatches;
    int          pending;
    int          tx_idle_pct = 35;
    int          rx_idle_pct = 74;

    compacting_array_queue_core #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    compacting_array_queue_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input caq_pkg::kind_t kind, input caq_pkg::word_t value,
                             input logic [2:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b0, pos, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic caq_pkg::word_t pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return caq_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic caq_pkg::kind_t pick_kind(logic fill_heavy);
        int r;
        r = $urandom_range(99);
        if (fill_heavy) begin
            if (r < 50) return caq_pkg::KIND_ENQ;
            if (r < 65) return caq_pkg::KIND_DEQ;
            if (r < 82) return caq_pkg::KIND_READ;
            return caq_pkg::KIND_WRITE;
        end
        if (r < 25) return caq_pkg::KIND_ENQ;
        if (r < 60) return caq_pkg::KIND_DEQ;
        if (r < 80) return caq_pkg::KIND_READ;
        return caq_pkg::KIND_WRITE;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(pick_kind((n / 40) % 2 == 0), pick_value(), 3'($urandom_range(7)));
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial begin
        caq_pkg::word_t fill_words [8];
        fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_0001, 32'hffff_fffe};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue refusals
        send_item(caq_pkg::KIND_DEQ, 32'h0, 3'd0);
        send_item(caq_pkg::KIND_READ, 32'h0, 3'd0);
        send_item(caq_pkg::KIND_WRITE, 32'h1234_5678, 3'd7);
        // fill to full, then one refused
        foreach (fill_words[i]) send_item(caq_pkg::KIND_ENQ, fill_words[i], 3'(i));
        send_item(caq_pkg::KIND_ENQ, 32'h0bad_0bad, 3'd0);
        send_item(caq_pkg::KIND_READ, 32'h0, 3'd0);
        send_item(caq_pkg::KIND_READ, 32'h0, 3'd7);
        send_item(caq_pkg::KIND_WRITE, 32'h1234_5678, 3'd3);
        repeat (3) send_item(caq_pkg::KIND_DEQ, 32'h0, 3'd0);
        // below head
        send_item(caq_pkg::KIND_READ, 32'h0, 3'd1);
        // tail at end with head moved: compaction
        send_item(caq_pkg::KIND_ENQ, 32'hdead_beef, 3'd0);
        send_item(caq_pkg::KIND_READ, 32'h0, 3'd5);
        // dequeue down past the last entry
        repeat (7) send_item(caq_pkg::KIND_DEQ, 32'h0, 3'd0);
        wait_drained();

        run_random(220);
        tx_idle_pct = 74;
        rx_idle_pct = 35;
        run_random(220);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(210);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("compacting_array_queue_core_test: done, clean");
        end else begin
            $display("compacting_array_queue_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("compacting_array_queue_core_test: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/caq_pkg.sv
rtl/core/caq_cell.sv
rtl/core/compacting_array_queue_core.sv
test/compacting_array_queue_checker.sv
test/compacting_array_queue_core_test.sv
